// ----- rtl/core/lpg_pkg.sv -----
package lpg_pkg;

  // Input item kinds carried in tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Configuration register map (register index taken from paddr[2])
  localparam int   CFG_ADDR_W  = 3;
  localparam logic CFG_IDX_PEN = 1'b0;
  localparam int   RGB_W       = 24;

  // Walk phase of the current line
  typedef enum logic [1:0] {
    PASS_IDLE = 2'd0,
    PASS_X    = 2'd1,
    PASS_Y    = 2'd2
  } pass_t;

  // Front sequencer
  typedef enum logic [1:0] {
    FE_ACCEPT = 2'd0,
    FE_MUL_A  = 2'd1,
    FE_MUL_B  = 2'd2
  } fe_state_t;

  // Back sequencer
  typedef enum logic [1:0] {
    BE_IDLE = 2'd0,
    BE_DIV  = 2'd1,
    BE_DONE = 2'd2
  } be_state_t;

  // Per-pixel control carried with each job
  typedef struct packed {
    logic y_pass;
    logic last;
  } lpg_ctl_t;

endpackage

// ----- rtl/core/line_pixel_generator_unit.sv -----
// Load beat: accepted; input stalls in FE_MUL_A and FE_MUL_B while the cross product forms.
// Step beat on an active line: queued as a job; the divider pops it, forms one quotient bit per
// cycle in BE_DIV and loads the pixel into the output register in BE_DONE, which holds while
// the output is stalled. A new job is popped only once the divider is back in BE_IDLE.
// Step beat on an idle line: taken, no pixel. A 2-entry job queue sits in front
// of the divider. rst_n (synchronous, active low) clears pen color, endpoints, walk state.
module line_pixel_generator_unit import lpg_pkg::*; #(
  parameter int COORD_BITS = 10,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + RGB_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: x_start, y_start, x_end, y_end (from bit 0 up), zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  // in_tuser: func (load or step)
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: pixel_x, pixel_y, pixel_color (from bit 0 up), zero pad
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int N      = COORD_BITS;
  localparam int NUM_W  = 2 * COORD_BITS + 3;
  localparam int JOB_W  = NUM_W + (N + 1) + N + RGB_W + $bits(lpg_ctl_t);
  localparam int QDEPTH = 2;

  logic [RGB_W-1:0] pen_rgb_r;
  logic             cfg_wr;

  logic                    f_push_valid, f_push_ready;
  logic signed [NUM_W-1:0] f_num;
  logic signed [N:0]       f_den;
  logic [N-1:0]            f_fixed;
  logic [RGB_W-1:0]        f_color;
  lpg_ctl_t                f_ctl;

  logic                    b_job_valid, b_job_ready;
  logic [JOB_W-1:0]        q_in, q_out;
  logic signed [NUM_W-1:0] b_num;
  logic signed [N:0]       b_den;
  logic [N-1:0]            b_fixed;
  logic [RGB_W-1:0]        b_color;
  lpg_ctl_t                b_ctl;

  logic [N-1:0]     px, py;
  logic [RGB_W-1:0] pcolor;

  // Configuration port: write on the access cycle, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_PEN) ? {8'h00, pen_rgb_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_rgb_r <= '0;
    end else if (cfg_wr && (cfg_paddr[2] == CFG_IDX_PEN)) begin
      pen_rgb_r <= cfg_pwdata[RGB_W-1:0];
    end
  end

  lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tuser),
    .in_x_start (in_tdata[N-1:0]),
    .in_y_start (in_tdata[2*N-1:N]),
    .in_x_end   (in_tdata[3*N-1:2*N]),
    .in_y_end   (in_tdata[4*N-1:3*N]),
    .pen_rgb    (pen_rgb_r),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .job_num    (f_num),
    .job_den    (f_den),
    .job_fixed  (f_fixed),
    .job_color  (f_color),
    .job_ctl    (f_ctl)
  );

  assign q_in = {f_num, f_den, f_fixed, f_color, f_ctl};

  lpg_queue #(.WIDTH(JOB_W), .DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_data  (q_in),
    .pop_valid  (b_job_valid),
    .pop_ready  (b_job_ready),
    .pop_data   (q_out)
  );

  assign {b_num, b_den, b_fixed, b_color, b_ctl} = q_out;

  lpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (b_job_valid),
    .job_ready  (b_job_ready),
    .job_num    (b_num),
    .job_den    (b_den),
    .job_fixed  (b_fixed),
    .job_color  (b_color),
    .job_ctl    (b_ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_x      (px),
    .out_y      (py),
    .out_color  (pcolor),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_W'({pcolor, py, px});

endmodule

// ----- rtl/core/lpg_front.sv -----
module lpg_front import lpg_pkg::*; #(
  parameter int COORD_BITS = 10,
  localparam int N      = COORD_BITS,
  localparam int PROD_W = 2 * COORD_BITS + 2,
  localparam int NUM_W  = 2 * COORD_BITS + 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic [N-1:0]            in_x_start,
  input  logic [N-1:0]            in_y_start,
  input  logic [N-1:0]            in_x_end,
  input  logic [N-1:0]            in_y_end,
  input  logic [RGB_W-1:0]        pen_rgb,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic signed [NUM_W-1:0] job_num,
  output logic signed [N:0]       job_den,
  output logic [N-1:0]            job_fixed,
  output logic [RGB_W-1:0]        job_color,
  output lpg_ctl_t                job_ctl
);

  fe_state_t state_r, state_nxt;
  pass_t     phase_r, phase_nxt;

  logic [N-1:0] first_x_r, first_y_r, second_x_r, second_y_r;
  logic [N-1:0] walk_pos_r, walk_pos_nxt;
  logic [N-1:0] walk_limit_r, walk_limit_nxt;
  logic [N-1:0] pos_inc;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] k_r;
  logic signed [N:0]        mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [N:0]        dx, dy;
  logic signed [NUM_W-1:0]  prod_ext, k_ext;

  logic accept, is_load, active;

  assign accept  = in_valid && in_ready;
  assign is_load = (in_func == FUNC_LOAD);
  assign active  = (phase_r == PASS_X) || (phase_r == PASS_Y);

  assign dx = $signed({1'b0, second_x_r}) - $signed({1'b0, first_x_r});
  assign dy = $signed({1'b0, second_y_r}) - $signed({1'b0, first_y_r});

  // Shared multiplier: endpoint cross products after a load, coordinate difference times position on a step
  assign mul_p = mul_a * mul_b;

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_ACCEPT: begin
        if (accept && is_load) state_nxt = FE_MUL_A;
      end
      FE_MUL_A: state_nxt = FE_MUL_B;
      FE_MUL_B: state_nxt = FE_ACCEPT;
      default:  state_nxt = FE_ACCEPT;
    endcase
  end

  // Sequencer outputs and multiplier operand select
  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    mul_a      = $signed({1'b0, second_x_r});
    mul_b      = $signed({1'b0, first_y_r});
    case (state_r)
      FE_ACCEPT: begin
        in_ready   = push_ready;
        push_valid = in_valid && push_ready && !is_load && active;
        mul_a      = (phase_r == PASS_X) ? dy : dx;
        mul_b      = $signed({1'b0, walk_pos_r});
      end
      FE_MUL_A: begin
        mul_a = $signed({1'b0, second_x_r});
        mul_b = $signed({1'b0, first_y_r});
      end
      FE_MUL_B: begin
        mul_a = $signed({1'b0, first_x_r});
        mul_b = $signed({1'b0, second_y_r});
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Walk update: start a line on load, advance the position on each plotted pixel
  always_comb begin
    phase_nxt      = phase_r;
    walk_pos_nxt   = walk_pos_r;
    walk_limit_nxt = walk_limit_r;
    pos_inc        = walk_pos_r + 1'b1;
    if (accept && is_load) begin
      if (in_x_start != in_x_end) begin
        phase_nxt      = PASS_X;
        walk_pos_nxt   = (in_x_start < in_x_end) ? in_x_start : in_x_end;
        walk_limit_nxt = (in_x_start < in_x_end) ? in_x_end : in_x_start;
      end else if (in_y_start != in_y_end) begin
        phase_nxt      = PASS_Y;
        walk_pos_nxt   = (in_y_start < in_y_end) ? in_y_start : in_y_end;
        walk_limit_nxt = (in_y_start < in_y_end) ? in_y_end : in_y_start;
      end else begin
        phase_nxt = PASS_IDLE;
      end
    end else if (push_valid) begin
      walk_pos_nxt = pos_inc;
      if (pos_inc == walk_limit_r) begin
        if ((phase_r == PASS_X) && (first_y_r != second_y_r)) begin
          phase_nxt      = PASS_Y;
          walk_pos_nxt   = (first_y_r < second_y_r) ? first_y_r : second_y_r;
          walk_limit_nxt = (first_y_r < second_y_r) ? second_y_r : first_y_r;
        end else begin
          phase_nxt = PASS_IDLE;
        end
      end
    end
  end

  // Job for the divider: y pass negates the cross-product term
  assign prod_ext       = {mul_p[PROD_W-1], mul_p};
  assign k_ext          = {k_r[PROD_W-1], k_r};
  assign job_num        = (phase_r == PASS_X) ? (prod_ext + k_ext) : (prod_ext - k_ext);
  assign job_den        = (phase_r == PASS_X) ? dx : dy;
  assign job_fixed      = walk_pos_r;
  assign job_color      = pen_rgb;
  assign job_ctl.y_pass = (phase_r == PASS_Y);
  assign job_ctl.last   = (phase_nxt == PASS_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FE_ACCEPT;
      phase_r      <= PASS_IDLE;
      walk_pos_r   <= '0;
      walk_limit_r <= '0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      second_x_r   <= '0;
      second_y_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      walk_pos_r   <= walk_pos_nxt;
      walk_limit_r <= walk_limit_nxt;
      if (accept && is_load) begin
        first_x_r  <= in_x_start;
        first_y_r  <= in_y_start;
        second_x_r <= in_x_end;
        second_y_r <= in_y_end;
      end
    end
  end

  // Cross product x1*y0 - x0*y1, built in FE_MUL_A and FE_MUL_B after a load
  always_ff @(posedge clk) begin
    if (state_r == FE_MUL_A) prod_r <= mul_p;
    if (state_r == FE_MUL_B) k_r    <= prod_r - mul_p;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("job pushed into a full queue");

  a_mul_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FE_MUL_A) |=> (state_r == FE_MUL_B))
    else $error("cross product sequence broken");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PASS_IDLE) |-> (walk_pos_r < walk_limit_r))
    else $error("walk position past its limit");

endmodule

// ----- rtl/core/lpg_queue.sv -----
module lpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- rtl/core/lpg_back.sv -----
module lpg_back import lpg_pkg::*; #(
  parameter int COORD_BITS = 10,
  localparam int N     = COORD_BITS,
  localparam int NUM_W = 2 * COORD_BITS + 3,
  localparam int CNT_W = $clog2(2 * COORD_BITS + 3)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  output logic                    job_ready,
  input  logic signed [NUM_W-1:0] job_num,
  input  logic signed [N:0]       job_den,
  input  logic [N-1:0]            job_fixed,
  input  logic [RGB_W-1:0]        job_color,
  input  lpg_ctl_t                job_ctl,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [N-1:0]            out_x,
  output logic [N-1:0]            out_y,
  output logic [RGB_W-1:0]        out_color,
  output logic                    out_last
);

  be_state_t state_r, state_nxt;

  logic [NUM_W-1:0] dvd_r;
  logic [N-1:0]     rem_r;
  logic [N-1:0]     dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [N-1:0]     fixed_r;
  logic [RGB_W-1:0] color_r;
  lpg_ctl_t         ctl_r;

  logic             out_tvalid_r;
  logic [N-1:0]     out_x_r, out_y_r;
  logic [RGB_W-1:0] out_color_r;
  logic             out_last_r;

  logic [NUM_W-1:0] num_mag;
  logic [N:0]       den_mag;
  logic [N:0]       trial;
  logic             fits;
  logic [N-1:0]     quot;
  logic             pop, out_load;

  assign num_mag = job_num[NUM_W-1] ? NUM_W'(-job_num) : NUM_W'(job_num);
  assign den_mag = job_den[N] ? (N+1)'(-job_den) : (N+1)'(job_den);

  // One restoring step: bring down the next dividend bit
  assign trial = {rem_r, dvd_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});
  assign quot  = neg_r ? (~dvd_r[N-1:0] + 1'b1) : dvd_r[N-1:0];

  // Next state of the divider sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_IDLE: begin
        if (job_valid) state_nxt = BE_DIV;
      end
      BE_DIV: begin
        if (cnt_r == '0) state_nxt = BE_DONE;
      end
      BE_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = BE_IDLE;
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    job_ready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BE_IDLE: job_ready = 1'b1;
      BE_DONE: out_load  = !out_tvalid_r || out_tready;
      default: job_ready = 1'b0;
    endcase
  end

  assign pop = job_valid && job_ready;

  // Divider datapath: latch magnitudes, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      dvd_r   <= num_mag;
      rem_r   <= '0;
      dsr_r   <= den_mag[N-1:0];
      neg_r   <= job_num[NUM_W-1] ^ job_den[N];
      fixed_r <= job_fixed;
      color_r <= job_color;
      ctl_r   <= job_ctl;
    end else if (state_r == BE_DIV) begin
      dvd_r <= {dvd_r[NUM_W-2:0], fits};
      rem_r <= fits ? N'(trial - {1'b0, dsr_r}) : trial[N-1:0];
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BE_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) cnt_r <= CNT_W'(NUM_W - 1);
      else if (state_r == BE_DIV) cnt_r <= cnt_r - 1'b1;
      if (out_load)        out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r     <= ctl_r.y_pass ? quot : fixed_r;
      out_y_r     <= ctl_r.y_pass ? fixed_r : quot;
      out_color_r <= color_r;
      out_last_r  <= ctl_r.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_color  = out_color_r;
  assign out_last   = out_last_r;

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_DIV) |-> (dsr_r != '0))
    else $error("division by zero in progress");

  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_DIV) |-> (rem_r < dsr_r))
    else $error("partial remainder not below divisor");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_DONE && out_tvalid_r && !out_tready) |=> (state_r == BE_DONE))
    else $error("finished quotient dropped while output stalled");

endmodule
